/* rtl/qwts_pkg.sv */
// Shared types, constants and saturating arithmetic helpers for the
// quintic waypoint trajectory sampler. No dependencies.
package qwts_pkg;

  // Fixed field widths
  localparam int TW        = 32;   // time / position / velocity / accel
  localparam int CFG_W     = 7;    // points_in_use register
  localparam int SLOT_W    = 6;
  localparam int SEG_W     = 6;
  localparam int VW        = 39;   // internal value width, +-(2^38 - 1)
  localparam int DW        = 33;   // signed segment length
  localparam int ENTRY_W   = 4 * TW;
  localparam int NUM_W     = 64;   // divider numerator magnitude
  localparam int S_FRAC    = 30;   // fraction bits of the segment phase s

  localparam int DEF_WAYPOINTS = 64;
  localparam int DEF_FRAC_BITS = 16;
  localparam logic [CFG_W-1:0] POINTS_RESET = 7'd2;

  localparam logic signed [VW-1:0] W_LIM = 39'sh3F_FFFF_FFFF;
  localparam logic signed [47:0]   LIM48 = 48'sh3F_FFFF_FFFF;

  // Sequencer states
  typedef enum logic [4:0] {
    ST_IDLE, ST_SRCH, ST_SEL, ST_RDA, ST_RDB, ST_RDC, ST_CHK,
    ST_PRE_GO, ST_PRE_WT, ST_CF_A, ST_CF_B, ST_CF_C, ST_DIFF, ST_KSC,
    ST_SDIV_GO, ST_SDIV_WT, ST_HINIT, ST_HMUL_GO, ST_HMUL_WT,
    ST_DIV_GO, ST_DIV_WT, ST_STORE, ST_DONE
  } state_t;

  typedef enum logic [1:0] {MPH_IDLE, MPH_LO, MPH_HI, MPH_FIN} mul_phase_t;
  typedef enum logic [1:0] {DPH_IDLE, DPH_RUN, DPH_FIN} div_phase_t;

  // Divider pre-shift of the dividend
  typedef enum logic [1:0] {DSH_NONE, DSH_FRAC, DSH_S} div_sh_t;

  typedef struct packed {
    logic                   go;
    logic                   wide;   // shift by S_FRAC instead of FRAC_BITS
    logic signed [VW-1:0]   a;
    logic signed [VW-1:0]   b;
  } mul_req_t;

  typedef struct packed {
    logic                   go;
    div_sh_t                sh;
    logic signed [VW-1:0]   x;
    logic signed [DW-1:0]   d;
  } div_req_t;

  typedef struct packed {
    logic                   done;
    logic signed [VW-1:0]   value;
  } unit_rsp_t;

  function automatic logic signed [VW-1:0] sat48(input logic signed [47:0] x);
    if (x > LIM48) return W_LIM;
    else if (x < -LIM48) return -W_LIM;
    else return x[VW-1:0];
  endfunction

  function automatic logic signed [VW-1:0] sadd(input logic signed [VW-1:0] a,
                                                input logic signed [VW-1:0] b);
    logic signed [47:0] ea;
    logic signed [47:0] eb;
    ea = a;
    eb = b;
    return sat48(ea + eb);
  endfunction

  // Saturating scale by a small unsigned constant
  function automatic logic signed [VW-1:0] sscale(input logic signed [VW-1:0] a,
                                                  input logic [5:0] c);
    logic signed [47:0] ea;
    logic signed [47:0] ec;
    ea = a;
    ec = {42'd0, c};
    return sat48(ea * ec);
  endfunction

  function automatic logic [5:0] binom5(input logic [2:0] j);
    case (j)
      3'd0:    return 6'd1;
      3'd1:    return 6'd5;
      3'd2:    return 6'd10;
      3'd3:    return 6'd10;
      3'd4:    return 6'd5;
      3'd5:    return 6'd1;
      default: return 6'd0;
    endcase
  endfunction

  // Derivative factor of coefficient i in the m-th derivative
  function automatic logic [5:0] dfac(input logic [1:0] m, input logic [2:0] i);
    logic [5:0] f;
    f = 6'd1;
    case (m)
      2'd0: f = 6'd1;
      2'd1: f = 6'(i + 3'd1);
      2'd2: begin
        case (i)
          3'd0:    f = 6'd2;
          3'd1:    f = 6'd6;
          3'd2:    f = 6'd12;
          3'd3:    f = 6'd20;
          default: f = 6'd0;
        endcase
      end
      2'd3: begin
        case (i)
          3'd0:    f = 6'd6;
          3'd1:    f = 6'd24;
          3'd2:    f = 6'd60;
          default: f = 6'd0;
        endcase
      end
      default: f = 6'd0;
    endcase
    return f;
  endfunction

  function automatic logic [VW-2:0] mag39(input logic signed [VW-1:0] x);
    logic [VW-1:0] u;
    u = x[VW-1] ? -x : x;
    return u[VW-2:0];
  endfunction

  function automatic logic [DW-2:0] mag33(input logic signed [DW-1:0] x);
    logic [DW-1:0] u;
    u = x[DW-1] ? -x : x;
    return u[DW-2:0];
  endfunction

  function automatic logic [TW-1:0] out32(input logic signed [VW-1:0] x);
    if (x > 39'sh0_7FFF_FFFF) return 32'h7FFF_FFFF;
    else if (x < -39'sh0_8000_0000) return 32'h8000_0000;
    else return x[TW-1:0];
  endfunction

endpackage

/* rtl/qwts_mem.sv */
// Waypoint store: one write port, one read port, registered read data.
// Each entry packs time, position, velocity, acceleration. Uses qwts_pkg.
module qwts_mem #(
  parameter int DEPTH = qwts_pkg::DEF_WAYPOINTS,
  parameter int AW    = 6
) (
  input  logic                         clk,
  input  logic                         wr_en,
  input  logic [AW-1:0]                wr_addr,
  input  logic [qwts_pkg::ENTRY_W-1:0] wr_data,
  input  logic                         rd_en,
  input  logic [AW-1:0]                rd_addr,
  output logic [qwts_pkg::ENTRY_W-1:0] rd_data
);

  logic [qwts_pkg::ENTRY_W-1:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // read port, registered
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

/* rtl/qwts_mul.sv */
// Multi-cycle signed fractional multiplier: (a*b) >> sh, floor, saturated.
// Two 38x19 partial products, then shift and clamp. Uses qwts_pkg.
module qwts_mul #(
  parameter int FRAC_BITS = qwts_pkg::DEF_FRAC_BITS
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  qwts_pkg::mul_req_t   req,
  output qwts_pkg::unit_rsp_t  rsp
);

  localparam int MW = qwts_pkg::VW - 1;
  localparam int HW = MW / 2;
  localparam int PW = 2 * MW;
  localparam logic [PW-1:0] LIM_P = PW'({MW{1'b1}});

  qwts_pkg::mul_phase_t phase_r;
  logic                 done_r;
  logic [MW-1:0]        ua_r;
  logic [MW-1:0]        ub_r;
  logic                 neg_r;
  logic                 wide_r;
  logic [PW-1:0]        prod_r;
  logic signed [qwts_pkg::VW-1:0] res_r;

  logic [MW+HW-1:0]      pp_lo;
  logic [2*MW-HW-1:0]    pp_hi;
  logic [PW-1:0]         q;
  logic                  rem;
  logic [qwts_pkg::VW:0] mq;
  logic signed [qwts_pkg::VW-1:0] fin;

  // partial products
  assign pp_lo = ua_r * ub_r[HW-1:0];
  assign pp_hi = ua_r * ub_r[MW-1:HW];

  // shift, floor toward minus infinity, clamp
  always_comb begin
    if (wide_r) begin
      q   = prod_r >> qwts_pkg::S_FRAC;
      rem = (prod_r[qwts_pkg::S_FRAC-1:0] != '0);
    end else begin
      q   = prod_r >> FRAC_BITS;
      rem = (prod_r[FRAC_BITS-1:0] != '0);
    end
    mq = {1'b0, q[qwts_pkg::VW-1:0]} + {{qwts_pkg::VW{1'b0}}, rem};
    if (q > LIM_P) begin
      fin = neg_r ? -qwts_pkg::W_LIM : qwts_pkg::W_LIM;
    end else if (!neg_r) begin
      fin = q[qwts_pkg::VW-1:0];
    end else if (mq > {1'b0, qwts_pkg::W_LIM}) begin
      fin = -qwts_pkg::W_LIM;
    end else begin
      fin = -mq[qwts_pkg::VW-1:0];
    end
  end

  // control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= qwts_pkg::MPH_IDLE;
      done_r  <= 1'b0;
    end else begin
      done_r <= 1'b0;
      case (phase_r)
        qwts_pkg::MPH_IDLE: if (req.go) phase_r <= qwts_pkg::MPH_LO;
        qwts_pkg::MPH_LO:   phase_r <= qwts_pkg::MPH_HI;
        qwts_pkg::MPH_HI:   phase_r <= qwts_pkg::MPH_FIN;
        qwts_pkg::MPH_FIN: begin
          phase_r <= qwts_pkg::MPH_IDLE;
          done_r  <= 1'b1;
        end
        default: phase_r <= qwts_pkg::MPH_IDLE;
      endcase
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    case (phase_r)
      qwts_pkg::MPH_IDLE: begin
        if (req.go) begin
          ua_r   <= qwts_pkg::mag39(req.a);
          ub_r   <= qwts_pkg::mag39(req.b);
          neg_r  <= req.a[qwts_pkg::VW-1] ^ req.b[qwts_pkg::VW-1];
          wide_r <= req.wide;
        end
      end
      qwts_pkg::MPH_LO:  prod_r <= PW'(pp_lo);
      qwts_pkg::MPH_HI:  prod_r <= prod_r + (PW'(pp_hi) << HW);
      qwts_pkg::MPH_FIN: res_r  <= fin;
      default: ;
    endcase
  end

  assign rsp.done  = done_r;
  assign rsp.value = res_r;

endmodule

/* rtl/qwts_div.sv */
// Radix-4 restoring divider: (x << sh) / d, truncated toward zero, saturated.
// An iteration phase, then a finishing phase that negates and clamps. Uses qwts_pkg.
module qwts_div #(
  parameter int FRAC_BITS = qwts_pkg::DEF_FRAC_BITS
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  qwts_pkg::div_req_t   req,
  output qwts_pkg::unit_rsp_t  rsp
);

  localparam int NW  = qwts_pkg::NUM_W;
  localparam int RW  = qwts_pkg::DW - 1;
  localparam int ITW = $clog2(NW / 2);
  localparam logic [ITW-1:0] IT_LAST = ITW'(NW / 2 - 1);
  localparam logic [NW-1:0]  LIM_N   = NW'({(qwts_pkg::VW-1){1'b1}});

  qwts_pkg::div_phase_t phase_r;
  logic                 done_r;
  logic [ITW-1:0]       it_r;
  logic [NW-1:0]        qn_r;
  logic [RW-1:0]        rem_r;
  logic [RW-1:0]        dv_r;
  logic                 neg_r;
  logic signed [qwts_pkg::VW-1:0] res_r;

  logic [NW-1:0] num;
  logic [RW:0]   ra, rb;
  logic          ga, gb;
  logic [RW-1:0] ra2, rb2;
  logic [NW-1:0] qa, qb;

  // dividend magnitude with pre-shift
  always_comb begin
    case (req.sh)
      qwts_pkg::DSH_NONE: num = NW'(qwts_pkg::mag39(req.x));
      qwts_pkg::DSH_FRAC: num = NW'(qwts_pkg::mag39(req.x)) << FRAC_BITS;
      qwts_pkg::DSH_S:    num = NW'(qwts_pkg::mag39(req.x)) << qwts_pkg::S_FRAC;
      default:            num = '0;
    endcase
  end

  // two quotient bits per cycle
  always_comb begin
    ra  = {rem_r, qn_r[NW-1]};
    ga  = (ra >= {1'b0, dv_r});
    ra2 = ga ? RW'(ra - {1'b0, dv_r}) : ra[RW-1:0];
    qa  = {qn_r[NW-2:0], ga};
    rb  = {ra2, qa[NW-1]};
    gb  = (rb >= {1'b0, dv_r});
    rb2 = gb ? RW'(rb - {1'b0, dv_r}) : rb[RW-1:0];
    qb  = {qa[NW-2:0], gb};
  end

  // control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= qwts_pkg::DPH_IDLE;
      done_r  <= 1'b0;
      it_r    <= '0;
    end else begin
      done_r <= 1'b0;
      case (phase_r)
        qwts_pkg::DPH_IDLE: begin
          if (req.go) begin
            phase_r <= qwts_pkg::DPH_RUN;
            it_r    <= '0;
          end
        end
        qwts_pkg::DPH_RUN: begin
          it_r <= it_r + 1'b1;
          if (it_r == IT_LAST) phase_r <= qwts_pkg::DPH_FIN;
        end
        qwts_pkg::DPH_FIN: begin
          phase_r <= qwts_pkg::DPH_IDLE;
          done_r  <= 1'b1;
        end
        default: phase_r <= qwts_pkg::DPH_IDLE;
      endcase
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    case (phase_r)
      qwts_pkg::DPH_IDLE: begin
        if (req.go) begin
          qn_r  <= num;
          rem_r <= '0;
          dv_r  <= qwts_pkg::mag33(req.d);
          neg_r <= req.x[qwts_pkg::VW-1] ^ req.d[qwts_pkg::DW-1];
        end
      end
      qwts_pkg::DPH_RUN: begin
        qn_r  <= qb;
        rem_r <= rb2;
      end
      qwts_pkg::DPH_FIN: begin
        if (qn_r > LIM_N) res_r <= neg_r ? -qwts_pkg::W_LIM : qwts_pkg::W_LIM;
        else if (neg_r)   res_r <= -qn_r[qwts_pkg::VW-1:0];
        else              res_r <= qn_r[qwts_pkg::VW-1:0];
      end
      default: ;
    endcase
  end

  assign rsp.done  = done_r;
  assign rsp.value = res_r;

endmodule

/* rtl/quintic_waypoint_trajectory_sampler_core.sv */
// Quintic waypoint trajectory sampler. Load beats (mode 0) write one waypoint
// into the table and return nothing; sample beats (mode 1) return position,
// velocity, acceleration and jerk of the quintic Hermite segment holding
// in_time, in signed Q16.16 with saturation, plus the segment index and a
// zero-length flag. One item is worked on at a time. A load is written from
// the idle state and does not leave it. For a sample, the segment search reads
// one stored time per cycle from the single read port of the waypoint memory,
// then 20 shared-multiplier operations and 11 shared divider operations build
// and evaluate the polynomial; the divider dominates. A finished result waits
// in the output register while the next beat is accepted. points_in_use may
// only change while idle.
module quintic_waypoint_trajectory_sampler_core #(
  parameter int WAYPOINTS = qwts_pkg::DEF_WAYPOINTS,
  parameter int FRAC_BITS = qwts_pkg::DEF_FRAC_BITS
) (
  input  logic                             clk,
  input  logic                             rst_n,
  // configuration
  input  logic                             cfg_wr_en,
  input  logic [qwts_pkg::CFG_W-1:0]       cfg_wr_data,
  // input channel
  input  logic                             in_valid,
  output logic                             in_stall,
  input  logic                             in_mode,
  input  logic [qwts_pkg::SLOT_W-1:0]      in_slot,
  input  logic [qwts_pkg::TW-1:0]          in_time,
  input  logic signed [qwts_pkg::TW-1:0]   in_position,
  input  logic signed [qwts_pkg::TW-1:0]   in_velocity,
  input  logic signed [qwts_pkg::TW-1:0]   in_acceleration,
  // result channel
  output logic                             out_valid,
  input  logic                             out_stall,
  output logic signed [qwts_pkg::TW-1:0]   out_position,
  output logic signed [qwts_pkg::TW-1:0]   out_velocity,
  output logic signed [qwts_pkg::TW-1:0]   out_acceleration,
  output logic signed [qwts_pkg::TW-1:0]   out_jerk,
  output logic [qwts_pkg::SEG_W-1:0]       out_segment,
  output logic                             out_zero_length
);

  localparam int AW = (WAYPOINTS > 2) ? $clog2(WAYPOINTS) : 1;
  localparam int NW = AW + 1;
  localparam int VW = qwts_pkg::VW;
  localparam int TW = qwts_pkg::TW;
  localparam int DW = qwts_pkg::DW;

  qwts_pkg::state_t state_r, state_nxt;

  logic [qwts_pkg::CFG_W-1:0] piu_r;

  // search
  logic [TW-1:0] t_r, t0_r, prev_r;
  logic [NW-1:0] n_r, ra_r, n_clamp;
  logic [AW-1:0] cand_r, seg_r;

  // segment end states
  logic [TW-1:0]        t1_r, t2_r;
  logic signed [TW-1:0] p0_r, pn_r, v0_r, vn_r, a0_r, an_r;
  logic signed [DW-1:0] dd_r;
  logic signed [VW-1:0] vd0_r, vdn_r, x0_r, xn_r, add0_r, addn_r;
  logic [2:0]           pc_r;

  // coefficients and evaluation
  logic signed [VW-1:0] d_r [6];
  logic [2:0]           j_r, i_r;
  logic signed [VW-1:0] s_r, acc_r;
  logic [1:0]           m_r, dstep_r;
  logic [TW-1:0]        res_r [4];
  logic                 zl_r;

  // output register
  logic                 out_valid_r;
  logic [TW-1:0]        out_pos_r, out_vel_r, out_acc_r, out_jrk_r;
  logic [AW-1:0]        out_seg_r;
  logic                 out_zl_r;

  // memory and units
  logic                         mem_we, mem_re;
  logic [AW-1:0]                mem_waddr, mem_raddr;
  logic [qwts_pkg::ENTRY_W-1:0] mem_rdata;
  logic [TW-1:0]                rd_time;
  qwts_pkg::mul_req_t           mul_req;
  qwts_pkg::div_req_t           div_req;
  qwts_pkg::unit_rsp_t          mul_rsp, div_rsp;

  logic                 in_acc, slot_ok, out_free;
  logic [2:0]           ci, cidx;
  logic signed [VW-1:0] coef;
  logic signed [DW-1:0] tau;

  assign in_stall = (state_r != qwts_pkg::ST_IDLE);
  assign in_acc   = in_valid && !in_stall;
  assign slot_ok  = (32'(in_slot) < 32'(WAYPOINTS));
  assign out_free = !out_valid_r || !out_stall;
  assign rd_time  = mem_rdata[4*TW-1:3*TW];
  assign tau      = $signed({1'b0, t_r}) - $signed({1'b0, t1_r});

  // clamp the point count to the table
  always_comb begin
    if (piu_r < 7'd2)                      n_clamp = NW'(2);
    else if (32'(piu_r) > 32'(WAYPOINTS))  n_clamp = NW'(WAYPOINTS);
    else                                   n_clamp = NW'(piu_r);
  end

  // Horner coefficient of the current derivative
  always_comb begin
    ci   = (state_r == qwts_pkg::ST_HINIT) ? 3'(3'd5 - {1'b0, m_r}) : i_r;
    cidx = 3'(ci + {1'b0, m_r});
    coef = qwts_pkg::sscale(d_r[cidx], qwts_pkg::dfac(m_r, ci));
  end

  // waypoint store
  assign mem_we    = in_acc && !in_mode && slot_ok;
  assign mem_waddr = AW'(in_slot);

  qwts_mem #(.DEPTH(WAYPOINTS), .AW(AW)) u_mem (
    .clk     (clk),
    .wr_en   (mem_we),
    .wr_addr (mem_waddr),
    .wr_data ({in_time, in_position, in_velocity, in_acceleration}),
    .rd_en   (mem_re),
    .rd_addr (mem_raddr),
    .rd_data (mem_rdata)
  );

  qwts_mul #(.FRAC_BITS(FRAC_BITS)) u_mul (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (mul_req),
    .rsp   (mul_rsp)
  );

  qwts_div #(.FRAC_BITS(FRAC_BITS)) u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (div_req),
    .rsp   (div_rsp)
  );

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      qwts_pkg::ST_IDLE:    if (in_acc && in_mode) state_nxt = qwts_pkg::ST_SRCH;
      qwts_pkg::ST_SRCH:    if (ra_r == NW'(n_r - 1'b1)) state_nxt = qwts_pkg::ST_SEL;
      qwts_pkg::ST_SEL:     state_nxt = qwts_pkg::ST_RDA;
      qwts_pkg::ST_RDA:     state_nxt = qwts_pkg::ST_RDB;
      qwts_pkg::ST_RDB:     state_nxt = qwts_pkg::ST_RDC;
      qwts_pkg::ST_RDC:     state_nxt = qwts_pkg::ST_CHK;
      qwts_pkg::ST_CHK:     state_nxt = (t1_r == t2_r) ? qwts_pkg::ST_DONE
                                                       : qwts_pkg::ST_PRE_GO;
      qwts_pkg::ST_PRE_GO:  state_nxt = qwts_pkg::ST_PRE_WT;
      qwts_pkg::ST_PRE_WT: begin
        if (mul_rsp.done) begin
          state_nxt = (pc_r == 3'd5) ? qwts_pkg::ST_CF_A : qwts_pkg::ST_PRE_GO;
        end
      end
      qwts_pkg::ST_CF_A:    state_nxt = qwts_pkg::ST_CF_B;
      qwts_pkg::ST_CF_B:    state_nxt = qwts_pkg::ST_CF_C;
      qwts_pkg::ST_CF_C:    state_nxt = qwts_pkg::ST_DIFF;
      qwts_pkg::ST_DIFF:    if (j_r == 3'd5) state_nxt = qwts_pkg::ST_KSC;
      qwts_pkg::ST_KSC:     state_nxt = qwts_pkg::ST_SDIV_GO;
      qwts_pkg::ST_SDIV_GO: state_nxt = qwts_pkg::ST_SDIV_WT;
      qwts_pkg::ST_SDIV_WT: if (div_rsp.done) state_nxt = qwts_pkg::ST_HINIT;
      qwts_pkg::ST_HINIT:   state_nxt = qwts_pkg::ST_HMUL_GO;
      qwts_pkg::ST_HMUL_GO: state_nxt = qwts_pkg::ST_HMUL_WT;
      qwts_pkg::ST_HMUL_WT: begin
        if (mul_rsp.done) begin
          state_nxt = (i_r == 3'd0) ? qwts_pkg::ST_DIV_GO : qwts_pkg::ST_HMUL_GO;
        end
      end
      qwts_pkg::ST_DIV_GO:  state_nxt = qwts_pkg::ST_DIV_WT;
      qwts_pkg::ST_DIV_WT: begin
        if (div_rsp.done) begin
          state_nxt = (dstep_r == m_r) ? qwts_pkg::ST_STORE : qwts_pkg::ST_DIV_GO;
        end
      end
      qwts_pkg::ST_STORE:   state_nxt = (m_r == 2'd3) ? qwts_pkg::ST_DONE
                                                      : qwts_pkg::ST_HINIT;
      qwts_pkg::ST_DONE:    if (out_free) state_nxt = qwts_pkg::ST_IDLE;
      default:              state_nxt = qwts_pkg::ST_IDLE;
    endcase
  end

  // memory reads and unit requests
  always_comb begin
    mem_re    = 1'b0;
    mem_raddr = seg_r;
    mul_req   = '0;
    div_req   = '0;
    case (state_r)
      qwts_pkg::ST_SRCH: begin
        mem_re    = (ra_r < NW'(n_r - 1'b1));
        mem_raddr = ra_r[AW-1:0];
      end
      qwts_pkg::ST_RDA: begin
        mem_re    = 1'b1;
        mem_raddr = seg_r;
      end
      qwts_pkg::ST_RDB: begin
        mem_re    = 1'b1;
        mem_raddr = AW'(seg_r + 1'b1);
      end
      qwts_pkg::ST_PRE_GO: begin
        mul_req.go = 1'b1;
        mul_req.b  = VW'(dd_r);
        case (pc_r)
          3'd0:    mul_req.a = VW'(v0_r);
          3'd1:    mul_req.a = VW'(vn_r);
          3'd2:    mul_req.a = VW'(a0_r);
          3'd3:    mul_req.a = VW'(an_r);
          3'd4:    mul_req.a = x0_r;
          default: mul_req.a = xn_r;
        endcase
      end
      qwts_pkg::ST_SDIV_GO: begin
        div_req.go = 1'b1;
        div_req.sh = qwts_pkg::DSH_S;
        div_req.x  = VW'(tau);
        div_req.d  = dd_r;
      end
      qwts_pkg::ST_HMUL_GO: begin
        mul_req.go   = 1'b1;
        mul_req.wide = 1'b1;
        mul_req.a    = acc_r;
        mul_req.b    = s_r;
      end
      qwts_pkg::ST_DIV_GO: begin
        div_req.go = 1'b1;
        div_req.x  = acc_r;
        if (dstep_r == 2'd0) begin
          div_req.sh = qwts_pkg::DSH_NONE;
          div_req.d  = 33'sd20;
        end else begin
          div_req.sh = qwts_pkg::DSH_FRAC;
          div_req.d  = dd_r;
        end
      end
      default: ;
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= qwts_pkg::ST_IDLE;
      piu_r       <= qwts_pkg::POINTS_RESET;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (cfg_wr_en) piu_r <= cfg_wr_data;
      if (state_r == qwts_pkg::ST_DONE && out_free) out_valid_r <= 1'b1;
      else if (out_valid_r && !out_stall)           out_valid_r <= 1'b0;
    end
  end

  // sequencer datapath
  always_ff @(posedge clk) begin
    case (state_r)
      qwts_pkg::ST_IDLE: begin
        t_r    <= in_time;
        n_r    <= n_clamp;
        ra_r   <= '0;
        cand_r <= '0;
      end
      qwts_pkg::ST_SRCH: begin
        ra_r <= ra_r + 1'b1;
        if (ra_r != '0) begin
          prev_r <= rd_time;
          if (ra_r == NW'(1)) t0_r <= rd_time;
          else if (prev_r <= t_r && t_r < rd_time) cand_r <= AW'(ra_r - NW'(2));
        end
      end
      qwts_pkg::ST_SEL: begin
        if (t_r <= t0_r)        seg_r <= '0;
        else if (t_r >= prev_r) seg_r <= AW'(n_r - NW'(2));
        else                    seg_r <= cand_r;
      end
      qwts_pkg::ST_RDC, qwts_pkg::ST_RDB: begin
        if (state_r == qwts_pkg::ST_RDB) begin
          t1_r <= mem_rdata[4*TW-1:3*TW];
          p0_r <= mem_rdata[3*TW-1:2*TW];
          v0_r <= mem_rdata[2*TW-1:TW];
          a0_r <= mem_rdata[TW-1:0];
        end else begin
          t2_r <= mem_rdata[4*TW-1:3*TW];
          pn_r <= mem_rdata[3*TW-1:2*TW];
          vn_r <= mem_rdata[2*TW-1:TW];
          an_r <= mem_rdata[TW-1:0];
        end
      end
      qwts_pkg::ST_CHK: begin
        dd_r <= $signed({1'b0, t2_r}) - $signed({1'b0, t1_r});
        zl_r <= (t1_r == t2_r);
        pc_r <= '0;
        for (int q = 0; q < 4; q++) res_r[q] <= '0;
      end
      qwts_pkg::ST_PRE_WT: begin
        if (mul_rsp.done) begin
          pc_r <= pc_r + 1'b1;
          case (pc_r)
            3'd0:    vd0_r  <= mul_rsp.value;
            3'd1:    vdn_r  <= mul_rsp.value;
            3'd2:    x0_r   <= mul_rsp.value;
            3'd3:    xn_r   <= mul_rsp.value;
            3'd4:    add0_r <= mul_rsp.value;
            default: addn_r <= mul_rsp.value;
          endcase
        end
      end
      // scaled control points
      qwts_pkg::ST_CF_A: begin
        d_r[0] <= qwts_pkg::sscale(VW'(p0_r), 6'd20);
        d_r[5] <= qwts_pkg::sscale(VW'(pn_r), 6'd20);
        d_r[1] <= qwts_pkg::sscale(vd0_r, 6'd4);
        d_r[2] <= qwts_pkg::sscale(vd0_r, 6'd8);
        d_r[4] <= qwts_pkg::sscale(vdn_r, 6'd4);
        d_r[3] <= qwts_pkg::sscale(vdn_r, 6'd8);
      end
      qwts_pkg::ST_CF_B: begin
        d_r[1] <= qwts_pkg::sadd(d_r[0], d_r[1]);
        d_r[2] <= qwts_pkg::sadd(d_r[0], d_r[2]);
        d_r[3] <= qwts_pkg::sadd(d_r[5], -d_r[3]);
        d_r[4] <= qwts_pkg::sadd(d_r[5], -d_r[4]);
      end
      qwts_pkg::ST_CF_C: begin
        d_r[2] <= qwts_pkg::sadd(d_r[2], add0_r);
        d_r[3] <= qwts_pkg::sadd(d_r[3], addn_r);
        j_r    <= 3'd1;
      end
      // forward differences, one order per cycle
      qwts_pkg::ST_DIFF: begin
        j_r <= j_r + 1'b1;
        for (int q = 1; q < 6; q++) begin
          if (3'(q) >= j_r) d_r[q] <= qwts_pkg::sadd(d_r[q], -d_r[q-1]);
        end
      end
      qwts_pkg::ST_KSC: begin
        for (int q = 0; q < 6; q++) d_r[q] <= qwts_pkg::sscale(d_r[q], qwts_pkg::binom5(3'(q)));
      end
      qwts_pkg::ST_SDIV_WT: begin
        if (div_rsp.done) begin
          s_r <= div_rsp.value;
          m_r <= '0;
        end
      end
      qwts_pkg::ST_HINIT: begin
        acc_r <= coef;
        i_r   <= 3'(3'd4 - {1'b0, m_r});
      end
      qwts_pkg::ST_HMUL_WT: begin
        if (mul_rsp.done) begin
          acc_r   <= qwts_pkg::sadd(mul_rsp.value, coef);
          i_r     <= i_r - 1'b1;
          dstep_r <= '0;
        end
      end
      qwts_pkg::ST_DIV_WT: begin
        if (div_rsp.done) begin
          acc_r   <= div_rsp.value;
          dstep_r <= dstep_r + 1'b1;
        end
      end
      qwts_pkg::ST_STORE: begin
        res_r[m_r] <= qwts_pkg::out32(acc_r);
        m_r        <= m_r + 1'b1;
      end
      default: ;
    endcase
  end

  // output register load
  always_ff @(posedge clk) begin
    if (state_r == qwts_pkg::ST_DONE && out_free) begin
      out_pos_r <= res_r[0];
      out_vel_r <= res_r[1];
      out_acc_r <= res_r[2];
      out_jrk_r <= res_r[3];
      out_seg_r <= seg_r;
      out_zl_r  <= zl_r;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_position     = out_pos_r;
  assign out_velocity     = out_vel_r;
  assign out_acceleration = out_acc_r;
  assign out_jerk         = out_jrk_r;
  assign out_segment      = qwts_pkg::SEG_W'(out_seg_r);
  assign out_zero_length  = out_zl_r;

`ifndef SYNTHESIS
  // a zero-length segment always reports zero motion
  a_zero_len: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_zero_length |->
      out_position == 0 && out_velocity == 0 && out_acceleration == 0 && out_jerk == 0)
    else $error("zero-length result with nonzero motion");

  // a new result only comes out of the final sequencer state
  a_res_src: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(state_r == qwts_pkg::ST_DONE))
    else $error("result beat raised outside the done state");

  // a search only starts on an accepted sample beat
  a_srch_start: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == qwts_pkg::ST_SRCH && $past(state_r == qwts_pkg::ST_IDLE) |->
      $past(in_valid && !in_stall && in_mode))
    else $error("search started without a sample beat");
`endif

endmodule
